FILE: rtl/snn_pkg.sv
package snn_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // register indexes
  localparam logic REG_BACKSLASH_SEP = 1'b0;

  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h24, 8'h25, 8'h27, 8'h2d, 8'h5f, 8'h40, 8'h7e, 8'h60,
      8'h21, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5e, 8'h23, 8'h26: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] normalize_byte(input logic [7:0] c);
    logic [7:0] u;
    logic       ok;
    u = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      u = c - CASE_OFS;
    end
    ok = (u >= CH_UP_A && u <= CH_UP_Z) || (u >= CH_DIG_0 && u <= CH_DIG_9) ||
         (u == CH_NUL) || is_punct(u);
    return ok ? u : CH_UNDER;
  endfunction

endpackage

FILE: rtl/snn_front.sv
module snn_front import snn_pkg::*; #(
  parameter int BASE_LEN = 8,
  parameter int EXT_LEN  = 3,
  parameter int BCW      = $clog2(BASE_LEN + 1),
  parameter int ECW      = $clog2(EXT_LEN + 1),
  parameter int ENTRY_W  = 8 * (BASE_LEN + EXT_LEN) + BCW + ECW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bs_sep_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_char_i,
  input  logic               is_end_i,
  output logic               push_o,
  input  logic               full_i,
  output logic [ENTRY_W-1:0] entry_o
);

  logic [7:0]     base_q [BASE_LEN];
  logic [7:0]     ext_q  [EXT_LEN];
  logic [BCW-1:0] base_cnt_q, base_cnt_d;
  logic [ECW-1:0] ext_cnt_q, ext_cnt_d;
  logic           in_ext_q, in_ext_d;
  logic           accept;
  logic           is_sep;
  logic           base_we, ext_we;
  logic [7:0]     norm;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && is_end_i;
  assign norm       = normalize_byte(in_char_i);
  assign is_sep     = (in_char_i == CH_SLASH) || (bs_sep_i && in_char_i == CH_BSLASH);

  always_comb begin
    base_cnt_d = base_cnt_q;
    ext_cnt_d  = ext_cnt_q;
    in_ext_d   = in_ext_q;
    base_we    = 1'b0;
    ext_we     = 1'b0;
    if (accept) begin
      priority if (is_end_i || is_sep) begin
        base_cnt_d = '0;
        ext_cnt_d  = '0;
        in_ext_d   = 1'b0;
      end else if (in_char_i == CH_DOT && !in_ext_q) begin
        in_ext_d = 1'b1;
      end else if (!in_ext_q) begin
        if (base_cnt_q < BCW'(BASE_LEN)) begin
          base_we    = 1'b1;
          base_cnt_d = base_cnt_q + 1'b1;
        end
      end else begin
        if (ext_cnt_q < ECW'(EXT_LEN)) begin
          ext_we    = 1'b1;
          ext_cnt_d = ext_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cnt_q <= '0;
      ext_cnt_q  <= '0;
      in_ext_q   <= 1'b0;
    end else begin
      base_cnt_q <= base_cnt_d;
      ext_cnt_q  <= ext_cnt_d;
      in_ext_q   <= in_ext_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BASE_LEN; i++) begin
      if (base_we && base_cnt_q == BCW'(i)) begin
        base_q[i] <= norm;
      end
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      if (ext_we && ext_cnt_q == ECW'(i)) begin
        ext_q[i] <= norm;
      end
    end
  end

  // entry: base bytes, ext bytes, base count, ext count from the lowest bit up
  always_comb begin
    entry_o = '0;
    for (int i = 0; i < BASE_LEN; i++) begin
      entry_o[8*i +: 8] = base_q[i];
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      entry_o[8*(BASE_LEN+i) +: 8] = ext_q[i];
    end
    entry_o[8*(BASE_LEN+EXT_LEN) +: BCW]     = base_cnt_q;
    entry_o[8*(BASE_LEN+EXT_LEN)+BCW +: ECW] = ext_cnt_q;
  end

endmodule

FILE: rtl/snn_queue.sv
module snn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/snn_back.sv
module snn_back import snn_pkg::*; #(
  parameter int BASE_LEN = 8,
  parameter int EXT_LEN  = 3,
  parameter int BCW      = $clog2(BASE_LEN + 1),
  parameter int ECW      = $clog2(EXT_LEN + 1),
  parameter int ENTRY_W  = 8 * (BASE_LEN + EXT_LEN) + BCW + ECW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [ENTRY_W-1:0] entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_char_o,
  output logic [3:0]         out_position_o,
  output logic               out_last_o
);

  localparam int TOTAL = BASE_LEN + EXT_LEN;
  localparam int PW    = $clog2(TOTAL);

  logic [PW-1:0]  pos_q, pos_d;
  logic [BCW-1:0] base_cnt;
  logic [ECW-1:0] ext_cnt;
  logic [31:0]    pos_ext;
  logic           accept;

  assign base_cnt    = entry_i[8*TOTAL +: BCW];
  assign ext_cnt     = entry_i[8*TOTAL+BCW +: ECW];
  assign out_valid_o = valid_i;
  assign out_last_o  = pos_q == PW'(TOTAL - 1);
  assign accept      = out_valid_o && out_ready_i;
  assign pop_o       = accept && out_last_o;
  assign pos_ext     = 32'(pos_q);
  assign out_position_o = pos_ext[3:0];

  always_comb begin
    out_char_o = CH_SPACE;
    for (int i = 0; i < BASE_LEN; i++) begin
      if (pos_q == PW'(i)) begin
        if (base_cnt == '0) begin
          out_char_o = (i == 0) ? CH_UNDER : CH_SPACE;
        end else if (BCW'(i) < base_cnt) begin
          out_char_o = entry_i[8*i +: 8];
        end
      end
    end
    for (int i = 0; i < EXT_LEN; i++) begin
      if (pos_q == PW'(BASE_LEN + i) && ECW'(i) < ext_cnt) begin
        out_char_o = entry_i[8*(BASE_LEN+i) +: 8];
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = out_last_o ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: rtl/short_name_normalizer_core.sv
// path bytes are taken one word per cycle unless the queue is full and cause no output; an end
// word queues the gathered name; BASE_LEN + EXT_LEN output words follow, one per cycle with
// tready high, the first in the cycle after the end word if none is ahead; the two-entry name
// queue lets up to two names wait; with both waiting the input stalls until the older drains
// async active-low reset empties the queue, clears the counts and the backslash option
module short_name_normalizer_core import snn_pkg::*; #(
  parameter int BASE_LEN = 8,
  parameter int EXT_LEN  = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [11:8] out_position, zero above
  output logic        m_axis_tlast,   // out_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BCW     = $clog2(BASE_LEN + 1);
  localparam int ECW     = $clog2(EXT_LEN + 1);
  localparam int ENTRY_W = 8 * (BASE_LEN + EXT_LEN) + BCW + ECW;

  logic               bs_sep_q;
  logic               push, pop, full, q_valid;
  logic [ENTRY_W-1:0] push_entry, head_entry;
  logic [7:0]         out_char;
  logic [3:0]         out_position;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BACKSLASH_SEP) ? {31'd0, bs_sep_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_sep_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BACKSLASH_SEP) begin
      bs_sep_q <= pwdata[0];
    end
  end

  snn_front #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bs_sep_i   (bs_sep_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .is_end_i   (s_axis_tlast),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  snn_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  snn_back #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_char_o     (out_char),
    .out_position_o (out_position),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_position, out_char};

endmodule

FILE: dv/short_name_normalizer_core_tb.sv
`timescale 1ns / 1ps

module short_name_normalizer_core_tb;
  import snn_pkg::*;

  localparam int BASE_LEN    = 8;
  localparam int EXT_LEN     = 3;
  localparam int NAME_LEN    = BASE_LEN + EXT_LEN;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 1000;
  localparam logic [2:0] SEP_ADDR = 3'(4 * int'(REG_BACKSLASH_SEP));

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } path_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] pos;
    logic       last;
  } name_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  short_name_normalizer_core #(
    .BASE_LEN(BASE_LEN),
    .EXT_LEN (EXT_LEN)
  ) dut (.*);

  // allowed punctuation bytes
  logic [7:0] punct_bytes [16] = '{8'h24, 8'h25, 8'h27, 8'h2d, 8'h5f, 8'h40, 8'h7e, 8'h60,
                                   8'h21, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5e, 8'h23, 8'h26};

  path_item_t path_q [$];
  name_byte_t name_q [$];

  // shadow of the name builder
  logic       bs_sep = 1'b0;
  logic [7:0] base_mem [BASE_LEN];
  logic [7:0] ext_mem [EXT_LEN];
  int         base_cnt = 0;
  int         ext_cnt = 0;
  logic       in_ext = 1'b0;

  int         fail_cnt = 0;
  int         in_acc_cnt = 0;
  int         in_sent_cnt = 0;
  int         out_acc_cnt = 0;
  int         out_seen_cnt = 0;
  logic       in_busy = 1'b0;
  int         in_gap = 0;
  int         in_calm = 0;
  int         out_gap = 0;
  int         out_calm = 0;
  logic       out_ready = 1'b0;
  path_item_t cur_item = '0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] fold_name_byte(input logic [7:0] c);
    logic [7:0] u;
    logic       ok;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
    ok = (u >= 8'h41 && u <= 8'h5a) || (u >= 8'h30 && u <= 8'h39) || (u == 8'h00);
    foreach (punct_bytes[i]) if (punct_bytes[i] == u) ok = 1'b1;
    return ok ? u : CH_UNDER;
  endfunction

  task automatic take_path_word(input logic [7:0] c, input logic is_end);
    name_byte_t nb;
    logic [7:0] ch;
    if (!is_end) begin
      if (c == CH_SLASH || (bs_sep && c == CH_BSLASH)) begin
        base_cnt = 0;
        ext_cnt  = 0;
        in_ext   = 1'b0;
      end else if (c == CH_DOT && !in_ext) begin
        in_ext = 1'b1;
      end else if (!in_ext) begin
        if (base_cnt < BASE_LEN) begin
          base_mem[base_cnt] = fold_name_byte(c);
          base_cnt++;
        end
      end else if (ext_cnt < EXT_LEN) begin
        ext_mem[ext_cnt] = fold_name_byte(c);
        ext_cnt++;
      end
    end else begin
      for (int k = 0; k < NAME_LEN; k++) begin
        ch = CH_SPACE;
        if (k < BASE_LEN) begin
          if (base_cnt == 0) begin
            if (k == 0) ch = CH_UNDER;
          end else if (k < base_cnt) begin
            ch = base_mem[k];
          end
        end else if (k - BASE_LEN < ext_cnt) begin
          ch = ext_mem[k - BASE_LEN];
        end
        nb.ch   = ch;
        nb.pos  = 4'(k);
        nb.last = (k == NAME_LEN - 1);
        name_q.insert(name_q.size(), nb);
      end
      base_cnt = 0;
      ext_cnt  = 0;
      in_ext   = 1'b0;
    end
  endtask

  // input acceptance and output checking
  always @(posedge clk_i) begin
    name_byte_t nb;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_path_word(s_axis_tdata, s_axis_tlast);
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_acc_cnt <= out_acc_cnt + 1;
        if (name_q.size() == 0) begin
          $error("unexpected word tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
          fail_cnt++;
        end else begin
          nb = name_q.pop_front();
          if (m_axis_tdata[7:0] !== nb.ch) begin
            $error("out_char expected %h actual %h", nb.ch, m_axis_tdata[7:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[11:8] !== nb.pos) begin
            $error("out_position expected %0d actual %0d", nb.pos, m_axis_tdata[11:8]);
            fail_cnt++;
          end
          if (m_axis_tdata[15:12] !== 4'h0) begin
            $error("tdata pad expected 0 actual %h", m_axis_tdata[15:12]);
            fail_cnt++;
          end
          if (m_axis_tlast !== nb.last) begin
            $error("out_last expected %b actual %b", nb.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  // path driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_busy && in_acc_cnt == in_sent_cnt) begin
        in_busy = 1'b0;
        in_gap  = draw_gap(in_calm);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (path_q.size() > 0) begin
          cur_item = path_q.pop_front();
          in_busy  = 1'b1;
          in_sent_cnt++;
        end
      end
      s_axis_tvalid <= in_busy;
      s_axis_tdata  <= cur_item.ch;
      s_axis_tlast  <= cur_item.last;
    end
  end

  // long receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // name receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc_cnt != out_seen_cnt) begin
        out_seen_cnt = out_acc_cnt;
        out_gap      = draw_gap(out_calm);
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ready = (out_gap == 0) && (hold_left == 0);
      m_axis_tready <= out_ready;
    end
  end

  task automatic push_byte(input logic [7:0] c);
    path_item_t it;
    it.ch   = c;
    it.last = 1'b0;
    path_q.insert(path_q.size(), it);
  endtask

  task automatic push_end();
    path_item_t it;
    it.ch   = 8'($urandom);
    it.last = 1'b1;
    path_q.insert(path_q.size(), it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_name_byte();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return 8'(8'h61 + $urandom_range(0, 25));
      5:             return 8'(8'h41 + $urandom_range(0, 25));
      6:             return 8'(8'h30 + $urandom_range(0, 9));
      7:             return punct_bytes[$urandom_range(0, 15)];
      8, 9:          return 8'($urandom);
      10:            return CH_DOT;
      default:       return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
    endcase
  endfunction

  task automatic push_random_path();
    int n;
    if ($urandom_range(0, 7) == 0) begin
      // raw noise
      n = $urandom_range(0, 10);
      repeat (n) push_byte(8'($urandom));
      push_end();
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 5);
      repeat (n) push_byte(rand_name_byte());
      push_byte($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 8);
    repeat (n) push_byte(rand_name_byte());
    if ($urandom_range(0, 4) != 0) begin
      push_byte(CH_DOT);
      n = $urandom_range(0, 5);
      repeat (n) push_byte(rand_name_byte());
    end
    push_end();
  endtask

  task automatic wait_idle();
    while (path_q.size() != 0 || in_busy || name_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_sep(input logic v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEP_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    bs_sep = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_sep(1'b0);
    // empty path
    push_end();
    // later dot inside the extension
    push_str("a.b.c");
    push_end();
    // byte 0, high byte, lower case, punctuation, backslash kept as a name byte
    push_byte(CH_NUL);
    push_byte(8'hff);
    push_str("z~\\");
    push_end();
    // empty base with extension
    push_str(".ab");
    push_end();
    wait_idle();

    write_sep(1'b1);
    // separators inside the extension
    push_str("a.b/c\\d");
    push_end();
    wait_idle();

    repeat (5) push_random_path();
    hold_req = 1'b1;
    wait_idle();

    write_sep(1'b0);
    repeat (3) push_random_path();
    wait_idle();

    write_sep(1'b1);
    repeat (3) push_random_path();
    wait_idle();

    write_sep(1'b0);
    repeat (2) push_random_path();
    wait_idle();

    repeat (30) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/snn_pkg.sv
rtl/snn_front.sv
rtl/snn_queue.sv
rtl/snn_back.sv
rtl/short_name_normalizer_core.sv
dv/short_name_normalizer_core_tb.sv
